### hw/rtl/hpg_pkg.sv
// shared types, constants and helpers of the hue ping-pong rgb generator
`default_nettype none

package hpg_pkg;

    // fixed limits of the design
    localparam logic [9:0]  MAX_LEDS      = 10'd1023;
    localparam logic [10:0] MAX_HUE_STEPS = 11'd1024;

    // configuration register indexes
    localparam logic [2:0] REG_LED_COUNT    = 3'd0;
    localparam logic [2:0] REG_HUE_STEPS    = 3'd1;
    localparam logic [2:0] REG_CHROMA_LEVEL = 3'd2;
    localparam logic [2:0] REG_FLOOR_LEVEL  = 3'd3;
    localparam logic [2:0] REG_HUE_FIRST    = 3'd4;
    localparam logic [2:0] REG_HUE_SECOND   = 3'd5;

    // turn mark codes
    localparam logic [1:0] MARK_NONE   = 2'd0;
    localparam logic [1:0] MARK_FIRST  = 2'd1;
    localparam logic [1:0] MARK_SECOND = 2'd2;

    // hsv sectors, named by the channel at chroma then the partial one
    localparam logic [2:0] SECT_RG = 3'd0;
    localparam logic [2:0] SECT_GR = 3'd1;
    localparam logic [2:0] SECT_GB = 3'd2;
    localparam logic [2:0] SECT_BG = 3'd3;
    localparam logic [2:0] SECT_BR = 3'd4;
    localparam logic [2:0] SECT_RB = 3'd5;

    // serial divider request: remainder preload, then dividend bits msb first
    typedef struct packed {
        logic        start;
        logic [3:0]  steps;
        logic [9:0]  rem_init;
        logic [9:0]  bits;
        logic [10:0] divisor;
    } hpg_div_req_t;

    typedef struct packed {
        logic       done;
        logic [9:0] quot;
        logic [9:0] rem;
    } hpg_div_rsp_t;

    // serial multiplier request: level times an 11-bit factor
    typedef struct packed {
        logic        start;
        logic [7:0]  level;
        logic [10:0] factor;
    } hpg_mul_req_t;

    typedef struct packed {
        logic        done;
        logic [17:0] product;
    } hpg_mul_rsp_t;

    function automatic logic [7:0] sat_add(input logic [7:0] v, input logic [7:0] f);
        logic [8:0] t;
        t = {1'b0, v} + {1'b0, f};
        return t[8] ? 8'hFF : t[7:0];
    endfunction

endpackage

`default_nettype wire

### hw/rtl/hpg_sdiv.sv
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none

module hpg_sdiv (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire hpg_pkg::hpg_div_req_t req,
    output hpg_pkg::hpg_div_rsp_t      rsp
);
    import hpg_pkg::*;

    logic [3:0]  cnt_reg,  cnt_next;
    logic        done_reg, done_next;
    logic [9:0]  rem_reg,  rem_next;
    logic [9:0]  quot_reg, quot_next;
    logic [9:0]  bits_reg, bits_next;
    logic [10:0] dvs_reg,  dvs_next;
    logic [10:0] trial;
    logic [10:0] diff;
    logic        ge;

    assign trial = {rem_reg, bits_reg[9]};
    assign ge    = (trial >= dvs_reg);
    assign diff  = trial - dvs_reg;

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        bits_next = bits_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            cnt_next  = req.steps;
            rem_next  = req.rem_init;
            bits_next = req.bits;
            dvs_next  = req.divisor;
            quot_next = '0;
        end
        else if (cnt_reg != 4'd0)
        begin
            cnt_next  = cnt_reg - 4'd1;
            done_next = (cnt_reg == 4'd1);
            rem_next  = ge ? diff[9:0] : trial[9:0];
            quot_next = {quot_reg[8:0], ge};
            bits_next = {bits_reg[8:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        bits_reg <= bits_next;
        dvs_reg  <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule

`default_nettype wire

### hw/rtl/hpg_smul.sv
// bit-serial shift-add multiplier, one level bit per cycle, msb first
`default_nettype none

module hpg_smul (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire hpg_pkg::hpg_mul_req_t req,
    output hpg_pkg::hpg_mul_rsp_t      rsp
);
    import hpg_pkg::*;

    logic [3:0]  cnt_reg,   cnt_next;
    logic        done_reg,  done_next;
    logic [17:0] acc_reg,   acc_next;
    logic [7:0]  level_reg, level_next;
    logic [10:0] fac_reg,   fac_next;

    always_comb
    begin
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        acc_next   = acc_reg;
        level_next = level_reg;
        fac_next   = fac_reg;
        if (req.start)
        begin
            cnt_next   = 4'd8;
            acc_next   = '0;
            level_next = req.level;
            fac_next   = req.factor;
        end
        else if (cnt_reg != 4'd0)
        begin
            cnt_next   = cnt_reg - 4'd1;
            done_next  = (cnt_reg == 4'd1);
            acc_next   = {acc_reg[16:0], 1'b0}
                         + (level_reg[7] ? {7'd0, fac_reg} : 18'd0);
            level_next = {level_reg[6:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        level_reg <= level_next;
        fac_reg   <= fac_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

endmodule

`default_nettype wire

### hw/rtl/hue_pingpong_rgb_generator_top.sv
// top level of the hue ping-pong rgb generator
`default_nettype none

// each input item is one led slot tick and gives exactly one result item.
// a slot counter runs from 0 to led_count; on the slot equal to led_count the
// current hue is turned into an 8-bit rgb color by the hsv sector rule, with
// chroma_level as chroma and floor_level added to each channel (saturated at
// 255), and color_valid is 1. on other ticks red, green and blue repeat the
// last color. after the last slot the hue steps up or down modulo the wheel
// size, and once hue_first has been met, each later meeting of hue_first or
// hue_second reverses the sweep. one item is handled at a time. the color tick
// runs a 3-step sector divide, an 8-step chroma multiply and an 8-step divide
// by the wheel size, all on one bit-serial divider and one bit-serial
// multiplier, and a tick whose hue is left above a shrunk wheel first runs a
// 10-step reduction of the hue. a finished result sits in the output
// register, so the next item is taken while it waits. configuration is
// written through cfg_we / cfg_index / cfg_data; the user must write it only
// while the block is idle, the block itself does not enforce this.
module hue_pingpong_rgb_generator_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input items
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        restart,
    // result items
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       red,
    output logic [7:0]       green,
    output logic [7:0]       blue,
    output logic             color_valid,
    // configuration writes
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [10:0] cfg_data
);
    import hpg_pkg::*;

    // sequencer states
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_CHK  = 4'd1;
    localparam logic [3:0] ST_MOD  = 4'd2;
    localparam logic [3:0] ST_SLOT = 4'd3;
    localparam logic [3:0] ST_SEC  = 4'd4;
    localparam logic [3:0] ST_MUL  = 4'd5;
    localparam logic [3:0] ST_X    = 4'd6;
    localparam logic [3:0] ST_WRAP = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;

    // configuration registers
    logic [9:0]  led_count_reg;
    logic [10:0] hue_steps_reg;
    logic [7:0]  chroma_level_reg;
    logic [7:0]  floor_level_reg;
    logic [9:0]  hue_first_reg;
    logic [9:0]  hue_second_reg;

    // block state
    logic [3:0]  state_reg,     state_next;
    logic [9:0]  slot_reg,      slot_next;
    logic [9:0]  hue_reg,       hue_next;
    logic [9:0]  last_hue_reg,  last_hue_next;
    logic        down_reg,      down_next;
    logic [1:0]  mark_reg,      mark_next;
    logic        tick_col_reg,  tick_col_next;
    logic [2:0]  sector_reg,    sector_next;
    logic [23:0] col_reg,       col_next;

    // output register, which also holds the last color
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  red_reg,       red_next;
    logic [7:0]  green_reg,     green_next;
    logic [7:0]  blue_reg,      blue_next;
    logic        cvalid_reg,    cvalid_next;

    hpg_div_req_t div_req;
    hpg_div_rsp_t div_rsp;
    hpg_mul_req_t mul_req;
    hpg_mul_rsp_t mul_rsp;

    logic [9:0]  leds;
    logic [10:0] steps;
    logic        hue_big;
    logic        color_slot;
    logic [12:0] hue_x6;
    logic [10:0] slot_inc;
    logic [10:0] hue_inc;
    logic [10:0] steps_m1;
    logic [10:0] part_fac;
    logic        at1;
    logic        at2;
    logic [1:0]  mark_tmp;
    logic        down_new;
    logic [7:0]  x_lvl;
    logic [7:0]  c_lvl;
    logic [7:0]  r_raw;
    logic [7:0]  g_raw;
    logic [7:0]  b_raw;
    logic        in_acc;
    logic        out_free;

    hpg_sdiv u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    hpg_smul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    // effective strip length and wheel size
    assign leds  = (led_count_reg > MAX_LEDS) ? MAX_LEDS : led_count_reg;
    always_comb
    begin
        if (hue_steps_reg == 11'd0)
            steps = 11'd1;
        else if (hue_steps_reg > MAX_HUE_STEPS)
            steps = MAX_HUE_STEPS;
        else
            steps = hue_steps_reg;
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign in_acc     = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;

    assign hue_big    = ({1'b0, hue_reg} >= steps);
    assign color_slot = (slot_reg == leds);
    assign hue_x6     = {1'b0, hue_reg, 2'b00} + {2'b00, hue_reg, 1'b0};
    assign slot_inc   = {1'b0, slot_reg} + 11'd1;
    assign hue_inc    = {1'b0, hue_reg} + 11'd1;
    assign steps_m1   = steps - 11'd1;

    // odd sectors fall, even ones rise
    assign part_fac   = div_rsp.quot[0] ? (steps - {1'b0, div_rsp.rem})
                                        : {1'b0, div_rsp.rem};

    // turning rule on the hue of the last color
    assign at1 = (last_hue_reg == hue_first_reg);
    assign at2 = (last_hue_reg == hue_second_reg);
    always_comb
    begin
        mark_tmp = mark_reg;
        down_new = down_reg;
        if (at1 || at2)
        begin
            if (mark_reg != MARK_NONE)
                down_new = !down_reg;
            if (at1 && (mark_reg == MARK_NONE || mark_reg == MARK_SECOND))
                mark_tmp = MARK_FIRST;
            if (at2 && mark_tmp == MARK_FIRST)
                mark_tmp = MARK_SECOND;
        end
    end

    // sector to channel mapping
    assign x_lvl = div_rsp.quot[7:0];
    assign c_lvl = chroma_level_reg;
    always_comb
    begin
        r_raw = 8'd0;
        g_raw = 8'd0;
        b_raw = 8'd0;
        case (sector_reg)
            SECT_RG:
            begin
                r_raw = c_lvl;
                g_raw = x_lvl;
            end
            SECT_GR:
            begin
                r_raw = x_lvl;
                g_raw = c_lvl;
            end
            SECT_GB:
            begin
                g_raw = c_lvl;
                b_raw = x_lvl;
            end
            SECT_BG:
            begin
                g_raw = x_lvl;
                b_raw = c_lvl;
            end
            SECT_BR:
            begin
                r_raw = x_lvl;
                b_raw = c_lvl;
            end
            default:
            begin
                r_raw = c_lvl;
                b_raw = x_lvl;
            end
        endcase
    end

    // requests to the serial units
    always_comb
    begin
        div_req          = '0;
        div_req.divisor  = steps;
        mul_req          = '0;
        mul_req.level    = chroma_level_reg;
        mul_req.factor   = part_fac;
        case (state_reg)
            ST_CHK:
            begin
                // full reduction of a hue left above a shrunk wheel
                div_req.start    = hue_big;
                div_req.steps    = 4'd10;
                div_req.rem_init = 10'd0;
                div_req.bits     = hue_reg;
            end
            ST_SLOT:
            begin
                // 6h / s: quotient below 6, so preload the top bits
                div_req.start    = color_slot;
                div_req.steps    = 4'd3;
                div_req.rem_init = hue_x6[12:3];
                div_req.bits     = {hue_x6[2:0], 7'd0};
            end
            ST_SEC:
            begin
                mul_req.start = div_rsp.done;
            end
            ST_MUL:
            begin
                // c*m / s: quotient below 256
                div_req.start    = mul_rsp.done;
                div_req.steps    = 4'd8;
                div_req.rem_init = mul_rsp.product[17:8];
                div_req.bits     = {mul_rsp.product[7:0], 2'd0};
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        hue_next       = hue_reg;
        last_hue_next  = last_hue_reg;
        down_next      = down_reg;
        mark_next      = mark_reg;
        tick_col_next  = tick_col_reg;
        sector_next    = sector_reg;
        col_next       = col_reg;
        out_valid_next = out_valid_reg && out_stall;
        red_next       = red_reg;
        green_next     = green_reg;
        blue_next      = blue_reg;
        cvalid_next    = cvalid_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (restart)
                    begin
                        slot_next     = '0;
                        hue_next      = '0;
                        last_hue_next = '0;
                        down_next     = 1'b0;
                        mark_next     = MARK_NONE;
                    end
                    state_next = ST_CHK;
                end
            end
            ST_CHK:
            begin
                state_next = hue_big ? ST_MOD : ST_SLOT;
            end
            ST_MOD:
            begin
                if (div_rsp.done)
                begin
                    hue_next   = div_rsp.rem;
                    state_next = ST_SLOT;
                end
            end
            ST_SLOT:
            begin
                tick_col_next = color_slot;
                if (color_slot)
                begin
                    last_hue_next = hue_reg;
                    state_next    = ST_SEC;
                end
                else
                begin
                    state_next = ST_WRAP;
                end
            end
            ST_SEC:
            begin
                if (div_rsp.done)
                begin
                    sector_next = div_rsp.quot[2:0];
                    state_next  = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (mul_rsp.done)
                    state_next = ST_X;
            end
            ST_X:
            begin
                if (div_rsp.done)
                begin
                    col_next   = {sat_add(r_raw, floor_level_reg),
                                  sat_add(g_raw, floor_level_reg),
                                  sat_add(b_raw, floor_level_reg)};
                    state_next = ST_WRAP;
                end
            end
            ST_WRAP:
            begin
                if (slot_inc > {1'b0, leds})
                begin
                    slot_next = '0;
                    down_next = down_new;
                    mark_next = mark_tmp;
                    if (down_new)
                        hue_next = (hue_reg == 10'd0) ? steps_m1[9:0] : hue_reg - 10'd1;
                    else
                        hue_next = (hue_inc >= steps) ? 10'd0 : hue_inc[9:0];
                end
                else
                begin
                    slot_next = slot_inc[9:0];
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    cvalid_next    = tick_col_reg;
                    if (tick_col_reg)
                    begin
                        red_next   = col_reg[23:16];
                        green_next = col_reg[15:8];
                        blue_next  = col_reg[7:0];
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_count_reg    <= 10'd60;
            hue_steps_reg    <= 11'd360;
            chroma_level_reg <= 8'd255;
            floor_level_reg  <= 8'd0;
            hue_first_reg    <= 10'd0;
            hue_second_reg   <= 10'd120;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LED_COUNT:    led_count_reg    <= cfg_data[9:0];
                REG_HUE_STEPS:    hue_steps_reg    <= cfg_data;
                REG_CHROMA_LEVEL: chroma_level_reg <= cfg_data[7:0];
                REG_FLOOR_LEVEL:  floor_level_reg  <= cfg_data[7:0];
                REG_HUE_FIRST:    hue_first_reg    <= cfg_data[9:0];
                REG_HUE_SECOND:   hue_second_reg   <= cfg_data[9:0];
                default:          led_count_reg    <= led_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            slot_reg      <= '0;
            hue_reg       <= '0;
            last_hue_reg  <= '0;
            down_reg      <= 1'b0;
            mark_reg      <= MARK_NONE;
            tick_col_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            red_reg       <= '0;
            green_reg     <= '0;
            blue_reg      <= '0;
            cvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            hue_reg       <= hue_next;
            last_hue_reg  <= last_hue_next;
            down_reg      <= down_next;
            mark_reg      <= mark_next;
            tick_col_reg  <= tick_col_next;
            out_valid_reg <= out_valid_next;
            red_reg       <= red_next;
            green_reg     <= green_next;
            blue_reg      <= blue_next;
            cvalid_reg    <= cvalid_next;
        end
    end

    // work registers of the color path
    always_ff @(posedge clk)
    begin
        sector_reg <= sector_next;
        col_reg    <= col_next;
    end

    assign out_valid   = out_valid_reg;
    assign red         = red_reg;
    assign green       = green_reg;
    assign blue        = blue_reg;
    assign color_valid = cvalid_reg;

endmodule

`default_nettype wire

### dv/tb_hue_pingpong_rgb_generator_top.sv
// testbench of the hue ping-pong rgb generator: tick driver, color predictor and result checker
`default_nettype none

module tb_hue_pingpong_rgb_generator_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hpg_pkg::*;

    // run shape
    localparam int SETTLE_CYCLES = 40;    // covers the slowest color tick plus a hue reduction
    localparam int QUIET_LIMIT   = 4000;  // cycles with no handshake or register write before giving up
    localparam int HOLD_CYCLES   = 150;   // long receiver hold-off
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_TICKS   = 47;
    localparam int REPORT_LIMIT  = 10;

    // one result item as seen on the output side
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       lit;
    } led_color_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // block ports, all driven to known values from time zero
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic        restart   = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        color_valid;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = REG_LED_COUNT;
    logic [10:0] cfg_data  = '0;

    hue_pingpong_rgb_generator_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .restart     (restart),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .color_valid (color_valid),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // ticks waiting to be offered (the restart bit of each) and colors waiting to come out
    logic       pending_ticks[$];
    led_color_t expected_colors[$];

    // idling percentages, set per phase by the stimulus process
    int send_idle_pct = 34;
    int recv_idle_pct = 65;

    // long hold-off handshake between stimulus and receiver process
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    // bookkeeping
    int ticks_sent    = 0;
    int colors_seen   = 0;
    int mismatch_cnt  = 0;
    int settings_used = 0;
    int quiet_cycles  = 0;

    // predictor copy of the configuration, reset values of the block
    logic [9:0]  led_reg    = 10'd60;
    logic [10:0] steps_reg  = 11'd360;
    logic [7:0]  chroma_reg = 8'd255;
    logic [7:0]  floor_reg  = 8'd0;
    logic [9:0]  first_reg  = 10'd0;
    logic [9:0]  second_reg = 10'd120;

    // predictor copy of the sweep state
    logic [10:0] slot_cnt   = '0;   // one bit wider to hold the count past the last slot
    logic [9:0]  hue_pos    = '0;
    logic [9:0]  last_hue   = '0;
    logic        sweep_down = 1'b0;
    logic [1:0]  turn_mark  = MARK_NONE;
    logic [23:0] held_rgb   = '0;

    // wheel size as actually used: zero means one, oversized is clamped
    function automatic int unsigned wheel_size(input logic [10:0] steps);
        if (steps == 0)
            return 1;
        if (steps > MAX_HUE_STEPS)
            return MAX_HUE_STEPS;
        return steps;
    endfunction

    // channel plus floor, saturated at full scale
    function automatic logic [7:0] lift(input logic [7:0] level);
        int unsigned t;
        t = level + floor_reg;
        return (t > 255) ? 8'hFF : 8'(t);
    endfunction

    // hsv sector rule at full saturation, chroma from the register
    function automatic logic [23:0] hue_to_rgb(input int unsigned h, input int unsigned s);
        int unsigned h6;
        int unsigned sector;
        int unsigned rem;
        int unsigned part;
        logic [7:0]  c;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        c      = chroma_reg;
        h6     = 6 * h;
        sector = h6 / s;
        rem    = h6 - sector * s;
        // rising edge of the ramp on even sectors, falling on odd ones
        part   = (sector % 2 == 1) ? (c * (s - rem)) / s : (c * rem) / s;
        r = '0;
        g = '0;
        b = '0;
        case (3'(sector))
            SECT_RG: begin r = c;        g = 8'(part); end
            SECT_GR: begin r = 8'(part); g = c;        end
            SECT_GB: begin g = c;        b = 8'(part); end
            SECT_BG: begin g = 8'(part); b = c;        end
            SECT_BR: begin r = 8'(part); b = c;        end
            default: begin r = c;        b = 8'(part); end
        endcase
        return {lift(r), lift(g), lift(b)};
    endfunction

    // one accepted tick: advance the sweep and queue the color it must show
    function automatic void advance_tick(input logic clear);
        int unsigned s;
        logic        lit;
        logic        at_first;
        logic        at_second;
        s   = wheel_size(steps_reg);
        lit = 1'b0;
        if (clear)
        begin
            slot_cnt   = '0;
            hue_pos    = '0;
            last_hue   = '0;
            sweep_down = 1'b0;
            turn_mark  = MARK_NONE;
        end
        // a hue left over from a larger wheel folds back into range
        hue_pos = 10'(hue_pos % s);
        if (slot_cnt == {1'b0, led_reg})
        begin
            last_hue = hue_pos;
            held_rgb = hue_to_rgb(hue_pos, s);
            lit      = 1'b1;
        end
        slot_cnt = slot_cnt + 11'd1;
        if (slot_cnt > {1'b0, led_reg})
        begin
            // turning looks at the last hue shown, even if this wrap showed none
            at_first  = (last_hue == first_reg);
            at_second = (last_hue == second_reg);
            if (at_first || at_second)
            begin
                if (turn_mark != MARK_NONE)
                    sweep_down = !sweep_down;
                if (at_first && (turn_mark == MARK_NONE || turn_mark == MARK_SECOND))
                    turn_mark = MARK_FIRST;
                if (at_second && turn_mark == MARK_FIRST)
                    turn_mark = MARK_SECOND;
            end
            slot_cnt = '0;
            if (sweep_down)
                hue_pos = (hue_pos == 0) ? 10'(s - 1) : hue_pos - 10'd1;
            else
                hue_pos = (hue_pos + 1 >= s) ? 10'd0 : hue_pos + 10'd1;
        end
        expected_colors.push_back({held_rgb[23:16], held_rgb[15:8], held_rgb[7:0], lit});
    endfunction

    // count a failure, print only the first few
    task automatic report_miss(input string what, input int want, input int got);
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_LIMIT)
            $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    // tick driver: offers queued ticks, holds an item steady while stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            restart  <= 1'b0;
        end
        else
        begin
            // the tick on the port is taken at this edge
            if (in_valid && !in_stall)
            begin
                advance_tick(restart);
                ticks_sent++;
            end
            // port is free: offer the next tick or leave it idle
            if (!in_valid || !in_stall)
            begin
                if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    restart  <= pending_ticks.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // color monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        led_color_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_colors.size() == 0)
                begin
                    report_miss("result item with none expected", 0, 1);
                end
                else
                begin
                    want = expected_colors.pop_front();
                    if (red !== want.red)
                        report_miss("red", want.red, red);
                    if (green !== want.green)
                        report_miss("green", want.green, green);
                    if (blue !== want.blue)
                        report_miss("blue", want.blue, blue);
                    if (color_valid !== want.lit)
                        report_miss("color_valid", want.lit, color_valid);
                end
                if (color_valid === 1'b1)
                    colors_seen++;
            end
            // a long hold-off lets the block fill up and push back on its input
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
                out_stall   <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    // watchdog on cycles without any handshake or register write
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles, %0d colors still due",
                         QUIET_LIMIT, expected_colors.size());
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // register write, mirrored into the predictor
    task automatic write_reg(input logic [2:0] idx, input int unsigned value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 11'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_LED_COUNT:    led_reg    = 10'(value);
            REG_HUE_STEPS:    steps_reg  = 11'(value);
            REG_CHROMA_LEVEL: chroma_reg = 8'(value);
            REG_FLOOR_LEVEL:  floor_reg  = 8'(value);
            REG_HUE_FIRST:    first_reg  = 10'(value);
            REG_HUE_SECOND:   second_reg = 10'(value);
            default: ;
        endcase
    endtask

    // full register set for one phase
    task automatic configure(input int unsigned leds, input int unsigned steps,
                             input int unsigned chroma, input int unsigned floor_v,
                             input int unsigned first_v, input int unsigned second_v);
        write_reg(REG_LED_COUNT, leds);
        write_reg(REG_HUE_STEPS, steps);
        write_reg(REG_CHROMA_LEVEL, chroma);
        write_reg(REG_FLOOR_LEVEL, floor_v);
        write_reg(REG_HUE_FIRST, first_v);
        write_reg(REG_HUE_SECOND, second_v);
        settings_used++;
    endtask

    // queue ticks, each one a restart with a chance of restart_pct percent
    task automatic add_ticks(input int count, input int restart_pct);
        @(negedge clk);
        repeat (count)
            pending_ticks.push_back($urandom_range(0, 99) < restart_pct);
    endtask

    // wait until every tick is taken and every color has come out, then let the block go quiet
    task automatic settle();
        while (pending_ticks.size() != 0 || in_valid || expected_colors.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        int unsigned leds;
        int unsigned steps;
        int unsigned wheel;
        int unsigned chroma;
        int unsigned floor_v;
        int unsigned first_v;
        int unsigned second_v;
        int          pick;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // first stretch: sender idles a third of the time, receiver two thirds

        // reset values: far from the color slot, so only the zero held color shows
        @(negedge clk);
        pending_ticks.push_back(1'b0);
        pending_ticks.push_back(1'b1);
        pending_ticks.push_back(1'b0);
        settle();

        // color on every tick over a wheel of six steps, swinging between hues 2 and 5
        // so all six sectors and both turns show up
        configure(0, 6, 255, 0, 2, 5);
        @(negedge clk);
        pending_ticks.push_back(1'b1);
        add_ticks(9, 0);
        settle();

        // zero wheel size works as one position; floor pushes red into saturation
        configure(0, 0, 200, 100, 2, 5);
        add_ticks(3, 0);
        settle();

        // longest strip and an oversized wheel: no color for a long while
        configure(1023, 2047, 255, 255, 1023, 1023);
        add_ticks(5, 0);
        settle();

        // strip shrunk below the slot count: wraps with the stale hue, then colors again
        write_reg(REG_LED_COUNT, 2);
        write_reg(REG_FLOOR_LEVEL, 0);
        add_ticks(5, 0);
        settle();

        // random phases: mostly short strips and small wheels so the sweep turns often
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 3)
            begin
                send_idle_pct = 65;
                recv_idle_pct = 34;
            end
            if (phase == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            pick = $urandom_range(0, 99);
            if (pick < 50)
                leds = $urandom_range(0, 2);
            else if (pick < 85)
                leds = $urandom_range(3, 8);
            else if (pick < 97)
                leds = $urandom_range(9, 40);
            else
                leds = $urandom_range(0, 1023);

            pick = $urandom_range(0, 99);
            if (pick < 60)
                steps = $urandom_range(6, 48);
            else if (pick < 70)
                steps = $urandom_range(0, 5);
            else if (pick < 80)
                steps = $urandom_range(49, 1024);
            else if (pick < 90)
                steps = MAX_HUE_STEPS;
            else
                steps = $urandom_range(1025, 2047);
            wheel = wheel_size(11'(steps));

            pick = $urandom_range(0, 99);
            chroma = (pick < 15) ? 0 : (pick < 30) ? 255 : $urandom_range(0, 255);
            pick = $urandom_range(0, 99);
            floor_v = (pick < 40) ? 0 : (pick < 55) ? 255 : $urandom_range(0, 255);

            // turning hues mostly on the wheel, sometimes anywhere in the field
            first_v  = ($urandom_range(0, 99) < 80) ? $urandom_range(0, wheel - 1)
                                                    : $urandom_range(0, 1023);
            second_v = ($urandom_range(0, 99) < 80) ? $urandom_range(0, wheel - 1)
                                                    : $urandom_range(0, 1023);

            // hue and slot carry over from the last phase, so a shrink gets exercised
            configure(leds, steps, chroma, floor_v, first_v, second_v);
            add_ticks(PHASE_TICKS, 3);

            // receiver backs off for a long stretch while the sender keeps offering
            if (phase == 7)
                hold_requests++;

            settle();
        end

        $display("run covered %0d ticks and %0d new colors over %0d register settings,",
                 ticks_sent, colors_seen, settings_used);
        $display("with idling on either side, none, and one long receiver hold-off");
        if (mismatch_cnt == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("%0d mismatches in total", mismatch_cnt);
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

`default_nettype wire

### files.f
hw/rtl/hpg_pkg.sv
hw/rtl/hpg_sdiv.sv
hw/rtl/hpg_smul.sv
hw/rtl/hue_pingpong_rgb_generator_top.sv
dv/tb_hue_pingpong_rgb_generator_top.sv
